@@ rtl/smcs_pkg.sv @@
// shared types and constants of the scan match candidate scorer
`default_nettype none

package smcs_pkg;

    localparam int KIND_BITS  = 2;
    localparam int CELL_BITS  = 16;
    localparam int VALUE_BITS = 8;
    localparam int SLOT_BITS  = 10;
    localparam int COORD_BITS = 16;
    localparam int HIT_BITS   = 18;
    localparam int SCORE_BITS = 17;
    localparam int IN_BITS    = 104;
    localparam int OUT_BITS   = 40;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int DIV_CNT_BITS  = 5;

    localparam logic [KIND_BITS-1:0] KIND_CELL  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_POINT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_SCORE = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_COUNT = 2'd2;

    typedef struct packed {
        logic load;
        logic start;
        logic scan;
        logic div_init;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/smcs_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module smcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/smcs_ctrl.sv @@
// controller state machine of the scan match candidate scorer
`default_nettype none

module smcs_ctrl
    import smcs_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic [KIND_BITS-1:0] in_kind,
    output logic                      s_tready,
    input  wire dp_status_t           status,
    output ctrl_cmd_t                 cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (in_kind == KIND_SCORE) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smcs_datapath.sv @@
// stores, point scan pipeline, score divider and output register
`default_nettype none

module smcs_datapath
    import smcs_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire ctrl_cmd_t                cmd,
    output dp_status_t                    status,
    input  wire logic [KIND_BITS-1:0]     in_kind,
    input  wire logic [CELL_BITS-1:0]     in_cell_index,
    input  wire logic [VALUE_BITS-1:0]    in_cell_value,
    input  wire logic [SLOT_BITS-1:0]     in_point_index,
    input  wire logic [COORD_BITS-1:0]    in_point_x,
    input  wire logic [COORD_BITS-1:0]    in_point_y,
    input  wire logic [COORD_BITS-1:0]    in_cand_x,
    input  wire logic [COORD_BITS-1:0]    in_cand_y,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [HIT_BITS-1:0]           out_hit_sum,
    output logic [SCORE_BITS-1:0]         out_score
);

    localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int GAW  = $clog2(GRID_DEPTH);
    localparam int CW   = $clog2(MAX_SIDE);
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int PIW  = $clog2(MAX_POINTS);
    localparam int PCW  = $clog2(MAX_POINTS + 1);
    localparam int SUMW = $clog2(MAX_POINTS * 255 + 1);
    localparam int RW   = SUMW + 1;
    localparam int SIDE_RST = (MAX_SIDE < 256) ? MAX_SIDE : 256;

    // configuration, saturated on write
    logic [SW-1:0]  width_reg;
    logic [SW-1:0]  height_reg;
    logic [PCW-1:0] count_reg;
    logic [8:0]     cfg_side;
    logic [SW-1:0]  cfg_side_sat;
    logic [9:0]     cfg_count;
    logic [PCW-1:0] cfg_count_sat;

    assign cfg_ready = 1'b1;
    assign cfg_side  = cfg_data[8:0];
    assign cfg_count = cfg_data[10:0] > 11'(MAX_POINTS) ? 10'd0 : 10'd0;

    always_comb begin
        if (32'(cfg_side) > 32'(MAX_SIDE)) begin
            cfg_side_sat = SW'(MAX_SIDE);
        end else begin
            cfg_side_sat = SW'(cfg_side);
        end
        if (32'(cfg_data) > 32'(MAX_POINTS)) begin
            cfg_count_sat = PCW'(MAX_POINTS);
        end else begin
            cfg_count_sat = PCW'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SW'(SIDE_RST);
            height_reg <= SW'(SIDE_RST);
            count_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  width_reg  <= cfg_side_sat;
                CFG_GRID_HEIGHT: height_reg <= cfg_side_sat;
                CFG_POINT_COUNT: count_reg  <= cfg_count_sat;
                default: ;
            endcase
        end
    end

    // store writes
    logic [GAW+CELL_BITS-1:0] cell_ext;
    logic [PIW+SLOT_BITS-1:0] slot_ext;
    logic                     grid_we;
    logic                     point_we;

    assign cell_ext = {GAW'(0), in_cell_index};
    assign slot_ext = {PIW'(0), in_point_index};
    assign grid_we  = cmd.load && (in_kind == KIND_CELL)
                      && (cell_ext < (GAW + CELL_BITS)'(GRID_DEPTH));
    assign point_we = cmd.load && (in_kind == KIND_POINT)
                      && (slot_ext < (PIW + SLOT_BITS)'(MAX_POINTS));

    // point issue
    logic [PCW-1:0]        idx_reg;
    logic                  issue;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] px_rd;
    logic [COORD_BITS-1:0] py_rd;

    assign issue = cmd.scan && (idx_reg < count_reg);

    smcs_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_px_ram (
        .aclk    (aclk),
        .wr_en   (point_we),
        .wr_addr (slot_ext[PIW-1:0]),
        .wr_data (in_point_x),
        .rd_en   (issue),
        .rd_addr (idx_reg[PIW-1:0]),
        .rd_data (px_rd)
    );

    smcs_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_py_ram (
        .aclk    (aclk),
        .wr_en   (point_we),
        .wr_addr (slot_ext[PIW-1:0]),
        .wr_data (in_point_y),
        .rd_en   (issue),
        .rd_addr (idx_reg[PIW-1:0]),
        .rd_data (py_rd)
    );

    // shift and bounds check
    logic                v1_reg;
    logic [COORD_BITS:0] sx;
    logic [COORD_BITS:0] sy;
    logic                inb;
    logic                hit2_reg;
    logic [CW-1:0]       xs_reg;
    logic [CW-1:0]       ys_reg;

    assign sx  = {px_rd[COORD_BITS-1], px_rd} + {cx_reg[COORD_BITS-1], cx_reg};
    assign sy  = {py_rd[COORD_BITS-1], py_rd} + {cy_reg[COORD_BITS-1], cy_reg};
    assign inb = !sx[COORD_BITS] && !sy[COORD_BITS]
                 && (sx < (COORD_BITS + 1)'(width_reg))
                 && (sy < (COORD_BITS + 1)'(height_reg));

    // cell address
    logic [CW+SW-1:0] prod;
    logic [CW+SW:0]   addr_full;
    logic [GAW-1:0]   a_reg;
    logic             hit3_reg;
    logic             hit4_reg;
    logic [VALUE_BITS-1:0] grid_rd;

    assign prod      = ys_reg * width_reg;
    assign addr_full = {1'b0, prod} + {(SW + 1)'(0), xs_reg};

    smcs_ram #(.WIDTH(VALUE_BITS), .DEPTH(GRID_DEPTH)) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (grid_we),
        .wr_addr (cell_ext[GAW-1:0]),
        .wr_data (in_cell_value),
        .rd_en   (hit3_reg),
        .rd_addr (a_reg),
        .rd_data (grid_rd)
    );

    // accumulate
    logic [SUMW-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            hit2_reg <= 1'b0;
            hit3_reg <= 1'b0;
            hit4_reg <= 1'b0;
        end else begin
            v1_reg   <= issue;
            hit2_reg <= v1_reg && inb;
            hit3_reg <= hit2_reg;
            hit4_reg <= hit3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        xs_reg <= sx[CW-1:0];
        ys_reg <= sy[CW-1:0];
        a_reg  <= addr_full[GAW-1:0];
        if (cmd.start) begin
            cx_reg  <= in_cand_x;
            cy_reg  <= in_cand_y;
            idx_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (issue) begin
                idx_reg <= idx_reg + PCW'(1);
            end
            if (hit4_reg) begin
                acc_reg <= acc_reg + SUMW'(grid_rd);
            end
        end
    end

    assign status.scan_done = (idx_reg == count_reg)
                              && !v1_reg && !hit2_reg && !hit3_reg && !hit4_reg;

    // restoring divider, one quotient bit per cycle
    logic [PCW+7:0]          d_full;
    logic [SUMW-1:0]         d_reg;
    logic [RW-1:0]           rem_reg;
    logic [SCORE_BITS-1:0]   quo_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [RW-1:0]           trial;
    logic                    ge;
    logic                    div_done;

    assign d_full   = {count_reg, 8'b0} - {8'b0, count_reg};
    assign trial    = (cnt_reg == '0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign ge       = trial >= {1'b0, d_reg};
    assign div_done = (cnt_reg == DIV_CNT_BITS'(SCORE_BITS));

    assign status.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            d_reg   <= d_full[SUMW-1:0];
            rem_reg <= {1'b0, acc_reg};
            quo_reg <= '0;
            cnt_reg <= '0;
        end else if (cmd.div_step && !div_done) begin
            rem_reg <= ge ? (trial - {1'b0, d_reg}) : trial;
            quo_reg <= {quo_reg[SCORE_BITS-2:0], ge};
            cnt_reg <= cnt_reg + DIV_CNT_BITS'(1);
        end
    end

    // output register
    logic [SUMW+HIT_BITS-1:0] acc_ext;

    assign acc_ext         = {HIT_BITS'(0), acc_reg};
    assign status.out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_hit_sum <= acc_ext[HIT_BITS-1:0];
            out_score   <= (count_reg == '0) ? '0 : quo_reg;
        end
    end

    logic unused_cfg;
    assign unused_cfg = ^cfg_count;

endmodule

`default_nettype wire

@@ rtl/scan_match_candidate_scorer.sv @@
// top level of the scan match candidate scorer
//
// channel  direction  fields
// s_       in         tuser: kind; tdata: cell_index cell_value point_index point_x
//                     point_y cand_x cand_y
// m_       out        tdata: hit_sum score
// cfg_     in         index 0 grid_width, 1 grid_height, 2 point_count
//
// load items are stored on acceptance and leave the input ready; a score item holds the
// input through one point store read per point and a 17-step serial divider.
// the finished result waits in the output register while load items go on.
// reset is synchronous and active low; stores are not cleared and hold
// whatever was last written. configuration is always ready.
`default_nettype none

module scan_match_candidate_scorer
    import smcs_pkg::*;
#(
    parameter int MAX_SIDE   = 256,
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // [97:0] cell_index, cell_value, point_index, point_x, point_y, cand_x, cand_y
    input  wire logic [IN_BITS-1:0]       s_tdata,
    // [1:0] kind
    input  wire logic [KIND_BITS-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [34:0] hit_sum, score
    output logic [OUT_BITS-1:0]           m_tdata,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic [HIT_BITS-1:0]   hit_sum;
    logic [SCORE_BITS-1:0] score;

    smcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_kind  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    smcs_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_kind        (s_tuser),
        .in_cell_index  (s_tdata[15:0]),
        .in_cell_value  (s_tdata[23:16]),
        .in_point_index (s_tdata[33:24]),
        .in_point_x     (s_tdata[49:34]),
        .in_point_y     (s_tdata[65:50]),
        .in_cand_x      (s_tdata[81:66]),
        .in_cand_y      (s_tdata[97:82]),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .out_hit_sum    (hit_sum),
        .out_score      (score)
    );

    assign m_tdata = {5'b0, score, hit_sum};

    logic unused_in;
    assign unused_in = ^s_tdata[IN_BITS-1:98];

endmodule

`default_nettype wire

@@ verif/tb_scan_match_candidate_scorer.sv @@
// self-checking testbench of the scan match candidate scorer
module tb_scan_match_candidate_scorer;
    import smcs_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 20000;
    localparam int GRID_CELLS  = 65536;
    localparam int POINT_SLOTS = 1024;

    typedef struct {
        logic [KIND_BITS-1:0]         kind;
        logic [CELL_BITS-1:0]         cell_index;
        logic [VALUE_BITS-1:0]        cell_value;
        logic [SLOT_BITS-1:0]         point_index;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] cand_x;
        logic signed [COORD_BITS-1:0] cand_y;
    } scan_item_t;

    typedef struct packed {
        logic [HIT_BITS-1:0]   hit;
        logic [SCORE_BITS-1:0] score;
    } score_res_t;

    typedef enum {ROW_CFG, ROW_ITEM} row_op_t;

    typedef struct {
        row_op_t                  op;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0] reg_val;
        scan_item_t               item;
        bit                       known;
        score_res_t               res;
    } stim_row_t;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata   = '0;
    logic [KIND_BITS-1:0]     s_tuser   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    logic [OUT_BITS-1:0]      m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    scan_match_candidate_scorer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // mirror of the block state
    logic [VALUE_BITS-1:0]        grid_cells [0:GRID_CELLS-1];
    logic signed [COORD_BITS-1:0] scan_px    [0:POINT_SLOTS-1];
    logic signed [COORD_BITS-1:0] scan_py    [0:POINT_SLOTS-1];
    logic [8:0]                   grid_w_reg = 9'd256;
    logic [8:0]                   grid_h_reg = 9'd256;
    logic [10:0]                  count_reg  = 11'd0;

    score_res_t pending_scores [$];
    stim_row_t  directed_rows [$];

    int send_idle_pct = 22;
    int recv_idle_pct = 75;
    int mismatches    = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int cfg_writes    = 0;

    function automatic int clamp(int v, int lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic score_res_t score_candidate(logic signed [COORD_BITS-1:0] cx,
                                                   logic signed [COORD_BITS-1:0] cy);
        score_res_t       r;
        int               w;
        int               h;
        int               p;
        int               j;
        int               x;
        int               y;
        longint unsigned  sum;
        longint unsigned  q;
        w = clamp(int'(grid_w_reg), 256);
        h = clamp(int'(grid_h_reg), 256);
        p = clamp(int'(count_reg), POINT_SLOTS);
        sum = 0;
        q = 0;
        if (w != 0 && h != 0 && p != 0) begin
            for (j = 0; j < p; j++) begin
                x = int'(scan_px[j]) + int'(cx);
                y = int'(scan_py[j]) + int'(cy);
                if (x >= 0 && y >= 0 && x < w && y < h)
                    sum += grid_cells[y * w + x];
            end
            q = (sum << 16) / (longint'(255) * p);
        end
        r.hit = sum[HIT_BITS-1:0];
        r.score = q[SCORE_BITS-1:0];
        return r;
    endfunction

    function automatic scan_item_t mk(logic [KIND_BITS-1:0] kind, logic [CELL_BITS-1:0] idx,
                                      logic [VALUE_BITS-1:0] val,
                                      logic signed [COORD_BITS-1:0] x,
                                      logic signed [COORD_BITS-1:0] y);
        scan_item_t it;
        it.kind = kind;
        it.cell_index = idx;
        it.cell_value = val;
        it.point_index = idx[SLOT_BITS-1:0];
        it.point_x = x;
        it.point_y = y;
        it.cand_x = x;
        it.cand_y = y;
        return it;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        stim_row_t r;
        r.op = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.item = mk(KIND_UNUSED, '0, '0, '0, '0);
        r.known = 1'b0;
        r.res = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_item(scan_item_t it, bit known, int hit, int sc);
        stim_row_t r;
        r.op = ROW_ITEM;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.item = it;
        r.known = known;
        r.res.hit = hit;
        r.res.score = sc;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_side();
        case ($urandom_range(15))
            0: return 11'd0;
            1: return 11'd256;
            2: return $urandom_range(257, 2047);
            3: return 11'd1;
            4, 5: return $urandom_range(25, 255);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    function automatic scan_item_t random_item();
        scan_item_t it;
        int         w;
        int         h;
        int         p;
        int         sel;
        w = clamp(int'(grid_w_reg), 256);
        h = clamp(int'(grid_h_reg), 256);
        p = clamp(int'(count_reg), POINT_SLOTS);
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        it.kind = KIND_UNUSED;
        it.cell_index = $urandom;
        it.cell_value = $urandom;
        it.point_index = $urandom;
        it.point_x = $urandom;
        it.point_y = $urandom;
        it.cand_x = $urandom;
        it.cand_y = $urandom;
        sel = $urandom_range(99);
        if (sel < 30) begin
            it.kind = KIND_CELL;
            if ($urandom_range(3) != 0)
                it.cell_index = $urandom_range(w * h - 1);
            if ($urandom_range(3) == 0)
                it.cell_value = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        end else if (sel < 55) begin
            it.kind = KIND_POINT;
            if (p != 0 && $urandom_range(3) != 0)
                it.point_index = $urandom_range(p - 1);
            if ($urandom_range(7) != 0) begin
                it.point_x = int'($urandom_range(w + 7)) - 4;
                it.point_y = int'($urandom_range(h + 7)) - 4;
            end
        end else if (sel < 95) begin
            it.kind = KIND_SCORE;
            if ($urandom_range(7) != 0) begin
                it.cand_x = int'($urandom_range(8)) - 4;
                it.cand_y = int'($urandom_range(8)) - 4;
            end
        end
        return it;
    endfunction

    task automatic send_item(input scan_item_t it, input bit known, input score_res_t known_res);
        score_res_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {{(IN_BITS-98){1'b0}}, it.cand_y, it.cand_x, it.point_y, it.point_x,
                    it.point_index, it.cell_value, it.cell_index};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (it.kind)
            KIND_CELL: grid_cells[it.cell_index] = it.cell_value;
            KIND_POINT: begin
                scan_px[it.point_index] = it.point_x;
                scan_py[it.point_index] = it.point_y;
            end
            KIND_SCORE: begin
                res = score_candidate(it.cand_x, it.cand_y);
                pending_scores.push_back(known ? known_res : res);
            end
            default: ;
        endcase
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_GRID_WIDTH: grid_w_reg = val[8:0];
            CFG_GRID_HEIGHT: grid_h_reg = val[8:0];
            CFG_POINT_COUNT: count_reg = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin : check_result
        score_res_t got;
        score_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit = m_tdata[HIT_BITS-1:0];
            got.score = m_tdata[HIT_BITS+SCORE_BITS-1:HIT_BITS];
            results_seen++;
            if (pending_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result hit_sum=%0d score=%0d", got.hit, got.score);
            end else begin
                want = pending_scores.pop_front();
                if (got.hit != want.hit || got.score != want.score) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected hit_sum=%0d score=%0d, got %0d %0d",
                                 results_seen, want.hit, want.score, got.hit, got.score);
                end
            end
        end
    end

    initial begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int i;
        int ph;
        int blk;
        int n;

        // score right after reset, no points in use
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 0, 0);
        add_cfg(CFG_POINT_COUNT, 11'd1);
        add_item(mk(KIND_POINT, 0, 0, 0, 0), 1'b0, 0, 0);
        add_item(mk(KIND_CELL, 0, 8'hFF, 0, 0), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 255, 65536);
        add_item(mk(KIND_CELL, 0, 8'h00, 0, 0), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 0, 0);
        // zero width, then zero height
        add_cfg(CFG_GRID_WIDTH, 11'd0);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 0, 0);
        add_cfg(CFG_GRID_WIDTH, 11'd256);
        add_cfg(CFG_GRID_HEIGHT, 11'd0);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 0, 0);
        // oversized sides saturate
        add_cfg(CFG_GRID_WIDTH, 11'h7FF);
        add_cfg(CFG_GRID_HEIGHT, 11'h1FF);
        add_item(mk(KIND_POINT, 0, 0, 32767, 32767), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, -32768, -32768), 1'b1, 0, 0);
        add_item(mk(KIND_POINT, 0, 0, -32768, -32768), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, 32767, 32767), 1'b1, 0, 0);
        add_item(mk(KIND_POINT, 0, 0, 255, 255), 1'b0, 0, 0);
        add_item(mk(KIND_CELL, 16'hFFFF, 8'hFF, 0, 0), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b1, 255, 65536);
        add_item(mk(KIND_SCORE, 0, 0, 1, 0), 1'b1, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, -255, -255), 1'b1, 0, 0);
        // full point store, then oversized count
        add_cfg(CFG_GRID_WIDTH, 11'd1);
        add_cfg(CFG_GRID_HEIGHT, 11'd1);
        add_cfg(CFG_POINT_COUNT, 11'd1024);
        add_item(mk(KIND_SCORE, 0, 0, -255, -255), 1'b0, 0, 0);
        add_cfg(CFG_POINT_COUNT, 11'h7FF);
        add_item(mk(KIND_SCORE, 0, 0, 0, 0), 1'b0, 0, 0);
        add_cfg(KIND_UNUSED, 11'h7FF);
        add_item(mk(KIND_UNUSED, 16'hFFFF, 8'hFF, -1, -1), 1'b0, 0, 0);
        add_item(mk(KIND_POINT, 1023, 0, -1, 1), 1'b0, 0, 0);
        add_item(mk(KIND_SCORE, 0, 0, 1, -1), 1'b0, 0, 0);

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // every cell and point slot is written before any score can read it
        for (i = 0; i < GRID_CELLS; i++)
            send_item(mk(KIND_CELL, i, $urandom_range(255), $urandom, $urandom), 1'b0, '0);
        for (i = 0; i < POINT_SLOTS; i++)
            send_item(mk(KIND_POINT, i, $urandom, int'($urandom_range(44)) - 4,
                         int'($urandom_range(44)) - 4), 1'b0, '0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].op == ROW_CFG) begin
                settle();
                cfg_write(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].res);
            end
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < 5; blk++) begin
                settle();
                cfg_write(CFG_GRID_WIDTH, pick_side());
                cfg_write(CFG_GRID_HEIGHT, pick_side());
                case ($urandom_range(7))
                    0: n = 0;
                    1: n = 1024;
                    2: n = $urandom_range(1025, 2047);
                    3: n = 1;
                    default: n = $urandom_range(2, 40);
                endcase
                cfg_write(CFG_POINT_COUNT, n[10:0]);
                for (i = 0; i < 37; i++)
                    send_item(random_item(), 1'b0, '0);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("%0d transactions in (%0d preload), %0d scores checked, %0d register writes",
                 items_sent, GRID_CELLS + POINT_SLOTS, results_seen, cfg_writes);
        $display("grid sides 0 to 511 with saturation, point counts 0 to 2047, three stall mixes");
        if (mismatches == 0 && pending_scores.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ scan_match_candidate_scorer.f @@
rtl/smcs_pkg.sv
rtl/smcs_ram.sv
rtl/smcs_ctrl.sv
rtl/smcs_datapath.sv
rtl/scan_match_candidate_scorer.sv
verif/tb_scan_match_candidate_scorer.sv
